### rtl/core/sht_pkg.sv
// ---------------------------------------------------------------------------
// Segment holder redirect table package
// Shared constants, entry layout and control types for the table core.
// ---------------------------------------------------------------------------
package sht_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	localparam int SEG_W     = 16;
	localparam int VIEW_W    = 8;
	localparam int TIME_W    = 32;
	localparam int BUF_W     = 16;
	localparam int REC_SEG_W = SEG_W + 1;
	localparam int EXP_W     = TIME_W + 1;
	localparam int CNT_W     = 32;

	typedef enum logic {
		OP_REQUEST = 1'b0,
		OP_ADVANCE = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FIN
	} state_t;

	// One stored table entry.
	typedef struct packed {
		logic [REC_SEG_W-1:0] segment;
		logic [VIEW_W-1:0]    view;
		logic [EXP_W-1:0]     expiry;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// One accepted input item as held by the scan engine.
	typedef struct packed {
		opcode_t           opcode;
		logic              is_initial;
		logic [SEG_W-1:0]  segment_id;
		logic [VIEW_W-1:0] view_id;
		logic [TIME_W-1:0] time_ms;
		logic [BUF_W-1:0]  buffer_ms;
	} job_t;

	// Status from the scan engine to the top level.
	typedef struct packed {
		logic idle;
		logic done;
		logic hit;
	} result_t;

endpackage

### rtl/core/sht_ram.sv
// ---------------------------------------------------------------------------
// Segment holder table RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module sht_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/sht_engine.sv
// ---------------------------------------------------------------------------
// Segment holder table scan engine
// Inserts new entries, then walks every table entry once per item to find
// a match or to retire expired entries.
// ---------------------------------------------------------------------------
module sht_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  sht_pkg::job_t  job,
	input  logic           out_free,
	output sht_pkg::result_t res
);
	import sht_pkg::*;

	state_t state_q, state_d;
	job_t   job_q;

	logic [TABLE_DEPTH-1:0] valid_q;
	logic [IDX_W-1:0]       ptr_q;
	logic [IDX_W-1:0]       rd_idx_q;
	logic [IDX_W-1:0]       idx_s1;
	logic                   vld_s1;
	logic                   hit_q;

	logic               ram_we;
	logic               ram_re;
	entry_t             wr_entry;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t             rd_entry;
	logic               match;
	logic               stale;
	logic               accept;

	sht_ram #(
		.DEPTH(TABLE_DEPTH),
		.WIDTH(ENTRY_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ptr_q),
		.wdata(wr_entry),
		.re   (ram_re),
		.raddr(rd_idx_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		accept         = start && (state_q == ST_IDLE);
		ram_we         = accept && (job.opcode == OP_REQUEST) && !job.is_initial;
		wr_entry.segment = {1'b0, job.segment_id} - REC_SEG_W'(1);
		wr_entry.view    = job.view_id;
		wr_entry.expiry  = {1'b0, job.time_ms} + EXP_W'(job.buffer_ms);
		ram_re         = (state_q == ST_SCAN);
		rd_entry       = entry_t'(ram_rdata);
		match = vld_s1 && valid_q[idx_s1] && (job_q.opcode == OP_REQUEST)
			&& (rd_entry.segment == {1'b0, job_q.segment_id})
			&& (rd_entry.view == job_q.view_id);
		stale = vld_s1 && valid_q[idx_s1] && (job_q.opcode == OP_ADVANCE)
			&& (rd_entry.expiry <= {1'b0, job_q.time_ms});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		res.idle = 1'b0;
		res.done = 1'b0;
		res.hit  = hit_q;
		unique case (state_q)
			ST_IDLE: begin
				res.idle = 1'b1;
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (rd_idx_q == LAST_IDX) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = (job_q.opcode == OP_REQUEST) ? ST_FIN : ST_IDLE;
			end
			ST_FIN: begin
				if (out_free) begin
					res.done = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			ptr_q    <= '0;
			rd_idx_q <= '0;
			idx_s1   <= '0;
			vld_s1   <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			vld_s1 <= ram_re;
			idx_s1 <= rd_idx_q;
			if (accept) begin
				rd_idx_q <= '0;
				hit_q    <= 1'b0;
			end else if (ram_re) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
			end
			if (ram_we) begin
				valid_q[ptr_q] <= 1'b1;
				ptr_q <= (ptr_q == LAST_IDX) ? '0 : ptr_q + IDX_W'(1);
			end
			if (match) begin
				hit_q <= 1'b1;
			end
			if (stale) begin
				valid_q[idx_s1] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_q <= job;
		end
	end

endmodule

### rtl/core/segment_holder_redirect_table_top.sv
// The engine takes a new item only when idle, so items do not overlap: it walks the single
// table RAM read port over all entries, one entry per cycle, then passes its drain state and,
// for a request, its finish state before it returns to idle. A time advance item produces
// no result and skips the finish state.
// A result held back by the receiver stalls the engine in its finish cycle.
// Reset (arst_n low) clears all valid bits, the insert pointer and the redirect count.
// ---------------------------------------------------------------------------
// Segment holder redirect table, top level
// Keeps a ring of recently completed segments and flags requests that hit.
// ---------------------------------------------------------------------------
module segment_holder_redirect_table_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         opcode,
	input  logic                         is_initial,
	input  logic [sht_pkg::SEG_W-1:0]    segment_id,
	input  logic [sht_pkg::VIEW_W-1:0]   view_id,
	input  logic [sht_pkg::TIME_W-1:0]   time_ms,
	input  logic [sht_pkg::BUF_W-1:0]    buffer_ms,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         redirected,
	output logic [sht_pkg::CNT_W-1:0]    redirect_count
);
	import sht_pkg::*;

	// The engine takes a new item whenever it is idle; a finished result may
	// still sit in the output register while the next item is already walking
	// the table.
	job_t    job;
	result_t res;
	logic    start;
	logic    out_free;

	logic             out_valid_q;
	logic             redirected_q;
	logic [CNT_W-1:0] count_q;

	always_comb begin
		job.opcode     = opcode_t'(opcode);
		job.is_initial = is_initial;
		job.segment_id = segment_id;
		job.view_id    = view_id;
		job.time_ms    = time_ms;
		job.buffer_ms  = buffer_ms;
		in_ready       = res.idle;
		start          = in_valid;
		// The engine only finishes a request when the output register can
		// take the result in the same cycle.
		out_free       = !out_valid_q || out_ready;
	end

	sht_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.job     (job),
		.out_free(out_free),
		.res     (res)
	);

	// The running redirect count doubles as the output payload. It only
	// changes when a new result is loaded, which happens only when the previous
	// one is gone or being taken, so it holds steady while a result waits unaccepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			redirected_q <= 1'b0;
			count_q      <= '0;
		end else begin
			if (res.done) begin
				out_valid_q  <= 1'b1;
				redirected_q <= res.hit;
				if (res.hit) begin
					count_q <= count_q + CNT_W'(1);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign redirected     = redirected_q;
	assign redirect_count = count_q;

	// A result is only produced when the output register is free.
	a_done_needs_space: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> (!out_valid_q || out_ready))
		else $error("result finished while output register was occupied");

	// Once an item is accepted, the engine is busy for the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("engine did not leave idle after accepting an item");

	// The redirect count moves only when a hitting request completes.
	a_count_only_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		!(res.done && res.hit) |=> (count_q == $past(count_q)))
		else $error("redirect count changed without a redirected request");

endmodule
